// ===== rtl/agc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants of the anagram group classifier
// Holds the alphabet size, field widths, status codes and the command and
// status bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W      = 5;
  localparam int GROUP_INDEX_W = 6;
  localparam int STATUS_W      = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_LONG = 2'd2
  } status_t;

  // Kind of result the controller commits at the end of a word.
  typedef enum logic [1:0] {
    RES_HIT  = 2'd0,
    RES_NEW  = 2'd1,
    RES_FULL = 2'd2,
    RES_LONG = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic      letter_en;
    logic      clear_all;
    logic      scan_start;
    logic      scan_run;
    logic      out_load;
    res_kind_t kind;
  } agc_cmd_t;

  typedef struct packed {
    logic word_ovf;
    logic hit;
    logic miss;
    logic table_full;
    logic out_free;
  } agc_stat_t;

endpackage

// ===== rtl/anagram_group_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// anagram_group_classifier: groups streamed words by their letter counts
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Words arrive one letter per transfer, with word_end set on the last letter
// and cmd set for a clear of the whole group table. Letters are taken one per
// cycle while the controller is idle and counted into a 26-entry histogram.
// The transfer that ends a word leads to the length check; a word that is
// not too long then walks the stored group signatures, one signature row
// per cycle out of the signature memory, whose single read port sets the
// pace. The walk ends at the first row that matches or once every open group
// has been read. A word that is too long commits its result from the check.
// The input is held from the end of a word until its result is committed.
// If a previous result is still waiting on the output, the check moves on
// only once that result is taken. Letters of the next word are taken while a
// result waits. A clear gives no result and leaves the input ready.
// Signature rows are written only when a group opens and are read only below
// the open group count, so the memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module anagram_group_classifier import agc_pkg::*; #(
  parameter int MAX_GROUPS   = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     cmd,
  input  logic [LETTER_W-1:0]      letter,
  input  logic                     word_end,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [GROUP_INDEX_W-1:0] group_index,
  output logic                     new_group,
  output logic [STATUS_W-1:0]      status
);

  agc_cmd_t  ctl;
  agc_stat_t stat;

  // The controller owns the input handshake and all sequencing decisions.
  agc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .word_end (word_end),
    .stat     (stat),
    .ctl      (ctl)
  );

  // The datapath holds the histogram, the signature memory and the result
  // register that drives the output channel.
  agc_datapath #(
    .MAX_GROUPS   (MAX_GROUPS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .letter      (letter),
    .ctl         (ctl),
    .stat        (stat),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .group_index (group_index),
    .new_group   (new_group),
    .status      (status)
  );

endmodule

// ===== rtl/agc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_datapath: histogram, signature memory and result register
// Counts letters into the word histogram, walks the stored group signatures
// one row per cycle and holds the result until it is taken.
// ----------------------------------------------------------------------------
module agc_datapath import agc_pkg::*; #(
  parameter int MAX_GROUPS   = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [LETTER_W-1:0]      letter,
  input  agc_cmd_t                 ctl,
  output agc_stat_t                stat,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [GROUP_INDEX_W-1:0] group_index,
  output logic                     new_group,
  output logic [STATUS_W-1:0]      status
);

  localparam int CW = $clog2(MAX_WORD_LEN + 1);
  localparam int GW = $clog2(MAX_GROUPS + 1);
  localparam int AW = $clog2(MAX_GROUPS);
  localparam int RW = ALPHABET_SIZE * CW;

  logic [CW-1:0] hist [ALPHABET_SIZE];
  logic [CW-1:0] word_len;
  logic          word_ovf;
  logic [RW-1:0] hist_flat;
  logic          letter_ok;
  logic          len_full;

  logic [GW-1:0] group_count;
  logic [GW-1:0] scan_ptr;
  logic          scan_more;
  logic          rd_vld;
  logic [GW-1:0] rd_idx;
  logic [RW-1:0] rd_data;
  logic [RW-1:0] sig_mem [MAX_GROUPS];
  logic          store_new;

  assign letter_ok = letter < LETTER_W'(ALPHABET_SIZE);
  assign len_full  = word_len >= CW'(MAX_WORD_LEN);
  assign store_new = ctl.out_load && (ctl.kind == RES_NEW);

  for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_flat
    assign hist_flat[k*CW +: CW] = hist[k];
  end

  // The histogram is emptied by a clear and whenever a result is committed.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all || ctl.out_load) begin
      for (int k = 0; k < ALPHABET_SIZE; k++) begin
        hist[k] <= '0;
      end
      word_len <= '0;
      word_ovf <= 1'b0;
    end else if (ctl.letter_en && letter_ok) begin
      if (len_full) begin
        word_ovf <= 1'b1;
      end else begin
        word_len <= word_len + CW'(1);
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
          if (letter == LETTER_W'(k)) begin
            hist[k] <= hist[k] + CW'(1);
          end
        end
      end
    end
  end

  assign scan_more = scan_ptr < group_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr <= '0;
      rd_vld   <= 1'b0;
    end else if (ctl.scan_start) begin
      scan_ptr <= '0;
      rd_vld   <= 1'b0;
    end else if (ctl.scan_run) begin
      rd_vld <= scan_more;
      if (scan_more) begin
        scan_ptr <= scan_ptr + GW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_run && scan_more) begin
      rd_data <= sig_mem[scan_ptr[AW-1:0]];
      rd_idx  <= scan_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (store_new) begin
      sig_mem[group_count[AW-1:0]] <= hist_flat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      group_count <= '0;
    end else if (store_new) begin
      group_count <= group_count + GW'(1);
    end
  end

  assign stat.word_ovf   = word_ovf;
  assign stat.hit        = rd_vld && (rd_data == hist_flat);
  assign stat.miss       = !rd_vld && !scan_more;
  assign stat.table_full = group_count == GW'(MAX_GROUPS);
  assign stat.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      case (ctl.kind)
        RES_HIT: begin
          group_index <= GROUP_INDEX_W'(rd_idx);
          new_group   <= 1'b0;
          status      <= STATUS_OK;
        end
        RES_NEW: begin
          group_index <= GROUP_INDEX_W'(group_count);
          new_group   <= 1'b1;
          status      <= STATUS_OK;
        end
        RES_FULL: begin
          group_index <= '0;
          new_group   <= 1'b0;
          status      <= STATUS_FULL;
        end
        RES_LONG: begin
          group_index <= '0;
          new_group   <= 1'b0;
          status      <= STATUS_LONG;
        end
        default: begin
          group_index <= '0;
          new_group   <= 1'b0;
          status      <= STATUS_OK;
        end
      endcase
    end
  end

endmodule

// ===== rtl/agc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_ctrl: controller of the anagram group classifier
// Takes letters while idle, then sequences the overflow check, the signature
// walk and the commit of one result per word.
// ----------------------------------------------------------------------------
module agc_ctrl import agc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      cmd,
  input  logic      word_end,
  input  agc_stat_t stat,
  output agc_cmd_t  ctl
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_SEARCH = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.kind   = RES_HIT;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (cmd) begin
            ctl.clear_all = 1'b1;
          end else begin
            ctl.letter_en = 1'b1;
            if (word_end) begin
              state_next = ST_CHECK;
            end
          end
        end
      end
      // Wait here until the result register can take the result, so the
      // walk never has to stall once it has begun.
      ST_CHECK: begin
        if (stat.out_free) begin
          if (stat.word_ovf) begin
            ctl.out_load = 1'b1;
            ctl.kind     = RES_LONG;
            state_next   = ST_IDLE;
          end else begin
            ctl.scan_start = 1'b1;
            state_next     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        ctl.scan_run = 1'b1;
        if (stat.hit) begin
          ctl.out_load = 1'b1;
          ctl.kind     = RES_HIT;
          state_next   = ST_IDLE;
        end else if (stat.miss) begin
          ctl.out_load = 1'b1;
          ctl.kind     = stat.table_full ? RES_FULL : RES_NEW;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/agc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_checker: port-level checks of the anagram group classifier
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module agc_checker import agc_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     cmd,
  input logic                     word_end,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [GROUP_INDEX_W-1:0] group_index,
  input logic                     new_group,
  input logic [STATUS_W-1:0]      status
);

  // An error result carries no group.
  a_err_no_group: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STATUS_OK) |-> (group_index == '0) && !new_group)
    else $error("error result carries a group index or new flag");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(group_index) &&
      $stable(new_group) && $stable(status))
    else $error("stalled result changed");

  // The end of a word always stalls the input for the check and the group walk.
  a_word_end_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !cmd && word_end |=> !in_ready)
    else $error("input not stalled after a word end");

  // A clear leaves the input ready for the next item.
  a_clear_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd |=> in_ready)
    else $error("input stalled after a clear");

endmodule

bind anagram_group_classifier agc_checker u_agc_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the anagram group classifier
// A short table of directed words and a long stream of random words are sent
// one letter per transfer. A behavioral classifier in the testbench predicts
// the group result of every finished word. Each result taken from the block
// is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import agc_pkg::*;

  localparam int MAX_GROUPS   = 64;
  localparam int MAX_WORD_LEN = 32;

  // Command codes on the cmd field.
  localparam logic CMD_WORD  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Letter codes of interest; codes above LETTER_Z are not counted.
  localparam logic [LETTER_W-1:0] LETTER_A   = 5'd0;
  localparam logic [LETTER_W-1:0] LETTER_Z   = 5'd25;
  localparam logic [LETTER_W-1:0] CODE_FIRST_NOISE = 5'd26;
  localparam logic [LETTER_W-1:0] CODE_TOP   = 5'd31;

  localparam int RANDOM_ITEMS = 780;
  localparam int CALM_ITEMS   = 690;   // no idling once this many have gone
  localparam int LONG_HOLD    = 300;   // cycles the receiver holds off once
  localparam int TAIL_CYCLES  = MAX_GROUPS + 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIRECTED_ROWS = 22;
  localparam int POOL_SIZE    = 16;
  localparam int POOL_LEN     = 8;

  typedef struct packed {
    logic [GROUP_INDEX_W-1:0] idx;
    logic                     fresh;
    status_t                  st;
  } word_result_t;

  // One row of the directed table. A row with reps above one repeats its
  // letter, with word_end applied only to the last copy.
  typedef struct packed {
    logic                c;
    logic [LETTER_W-1:0] l;
    logic                e;
    logic [5:0]          reps;
    logic                typed;
    word_result_t        res;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_ready;
  logic                     cmd;
  logic [LETTER_W-1:0]      letter;
  logic                     word_end;
  logic                     out_valid;
  logic                     out_ready;
  logic [GROUP_INDEX_W-1:0] group_index;
  logic                     new_group;
  logic [STATUS_W-1:0]      status;

  // Sideband that travels with the payload: a typed-in expectation that
  // replaces the predicted one for the transfer it rides on.
  logic         row_typed;
  word_result_t row_expect;

  anagram_group_classifier #(
    .MAX_GROUPS  (MAX_GROUPS),
    .MAX_WORD_LEN(MAX_WORD_LEN)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .letter     (letter),
    .word_end   (word_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .group_index(group_index),
    .new_group  (new_group),
    .status     (status)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: the histogram of the word in flight and the table of
  // group signatures, kept the same way the block keeps them.
  // --------------------------------------------------------------------------
  int unsigned hist [ALPHABET_SIZE];
  int unsigned word_len;
  bit          word_ovf;
  int unsigned signatures [MAX_GROUPS][ALPHABET_SIZE];
  int unsigned group_total;

  word_result_t expected_groups [$];
  int unsigned  fail_count;
  int unsigned  items_sent;
  int unsigned  cycle_count;

  // Control shared between the sender and the receiver.
  bit calm;
  bit hold_request;
  bit holding;

  function automatic void forget_word();
    int k;
    for (k = 0; k < ALPHABET_SIZE; k++) hist[k] = 0;
    word_len = 0;
    word_ovf = 1'b0;
  endfunction

  // Applies one accepted item to the predictor state. Returns 1 when the item
  // finishes a word, with the group result in r.
  function automatic bit classify_item(input logic c, input logic [LETTER_W-1:0] l,
                                       input logic e, output word_result_t r);
    bit matched;
    bit same;
    int g;
    int k;
    r.idx   = '0;
    r.fresh = 1'b0;
    r.st    = STATUS_OK;
    if (c == CMD_CLEAR) begin
      group_total = 0;
      forget_word();
      return 1'b0;
    end
    if (l <= LETTER_Z) begin
      if (word_len >= MAX_WORD_LEN) begin
        word_ovf = 1'b1;
      end else begin
        hist[l]++;
        word_len++;
      end
    end
    if (!e) return 1'b0;
    if (word_ovf) begin
      r.st = STATUS_LONG;
    end else begin
      matched = 1'b0;
      for (g = 0; g < group_total && !matched; g++) begin
        same = 1'b1;
        for (k = 0; k < ALPHABET_SIZE; k++) begin
          if (signatures[g][k] != hist[k]) same = 1'b0;
        end
        if (same) begin
          matched = 1'b1;
          r.idx   = GROUP_INDEX_W'(g);
        end
      end
      if (!matched) begin
        if (group_total >= MAX_GROUPS) begin
          r.st = STATUS_FULL;
        end else begin
          for (k = 0; k < ALPHABET_SIZE; k++) signatures[group_total][k] = hist[k];
          r.idx   = GROUP_INDEX_W'(group_total);
          r.fresh = 1'b1;
          group_total++;
        end
      end
    end
    forget_word();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge, where the values
  // seen are the ones that held just before it. The input transfer is
  // predicted first, so a result can never race its own prediction.
  // --------------------------------------------------------------------------
  word_result_t predicted;
  word_result_t oldest;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (classify_item(cmd, letter, word_end, predicted)) begin
          expected_groups.insert(expected_groups.size(),
                                 row_typed ? row_expect : predicted);
        end
      end
      if (out_valid && out_ready) begin
        if (expected_groups.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result: group_index=%0d new_group=%0b status=%0d",
                     group_index, new_group, status);
          end
        end else begin
          oldest = expected_groups.pop_front();
          if (group_index !== oldest.idx || new_group !== oldest.fresh ||
              status !== oldest.st) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: exp idx=%0d new=%0b st=%0d, got idx=%0d new=%0b st=%0d",
                       oldest.idx, oldest.fresh, oldest.st,
                       group_index, new_group, status);
            end
          end
        end
      end
    end
  end

  // The run is cut off if it ever takes far longer than the slowest correct
  // run would: every word walking the full table behind the longest stalls.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver. It stalls in short random bursts, once holds off for a long
  // stretch so that the block fills up and stops taking letters, and goes
  // quiet in the last part of the run.
  // --------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    holding   = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        out_ready   <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holding = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        if (calm) begin
          @(posedge clk);
        end else begin
          repeat ($urandom_range(1, 15)) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender.
  // --------------------------------------------------------------------------

  // Offers one item and returns at the edge where the transfer happens.
  // Valid is lowered only at the start of an idle burst, so it is never
  // lowered and raised within one time step.
  task automatic offer(input logic c, input logic [LETTER_W-1:0] l, input logic e,
                       input logic typed, input word_result_t res);
    if (!calm && !holding && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= c;
    letter     <= l;
    word_end   <= e;
    row_typed  <= typed;
    row_expect <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering until every predicted result has come out, then lets the
  // block settle for a walk over the whole table.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_groups.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Word under construction for the random part.
  logic [LETTER_W-1:0] wl [48];
  logic [LETTER_W-1:0] pool [POOL_SIZE][POOL_LEN];
  int                  pool_len [POOL_SIZE];
  word_result_t        no_result;

  task automatic send_word(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      offer(CMD_WORD, wl[i], (i == n - 1), 1'b0, no_result);
    end
  endtask

  function automatic stim_row_t mk(input logic c, input logic [LETTER_W-1:0] l,
                                   input logic e, input int reps, input logic typed,
                                   input int idx, input logic fresh, input status_t st);
    stim_row_t row;
    row.c         = c;
    row.l         = l;
    row.e         = e;
    row.reps      = 6'(reps);
    row.typed     = typed;
    row.res.idx   = GROUP_INDEX_W'(idx);
    row.res.fresh = fresh;
    row.res.st    = st;
    return row;
  endfunction

  stim_row_t directed [DIRECTED_ROWS];

  initial begin
    int r;
    int n;
    int i;
    int j;
    int k;
    int slot;
    logic [LETTER_W-1:0] tmp;
    bit did_hold;
    bit did_fill;

    rst          = 1'b1;
    in_valid     = 1'b0;
    cmd          = CMD_WORD;
    letter       = LETTER_A;
    word_end     = 1'b0;
    row_typed    = 1'b0;
    row_expect   = '0;
    no_result    = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    group_total  = 0;
    forget_word();

    // Directed words. Results are typed in where they are plain: the first
    // groups after reset, repeats of them, and the error codes.
    directed[0]  = mk(CMD_CLEAR, CODE_TOP, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[1]  = mk(CMD_WORD, LETTER_A, 1'b1, 1, 1'b1, 0, 1'b1, STATUS_OK);
    directed[2]  = mk(CMD_WORD, LETTER_Z, 1'b1, 1, 1'b1, 1, 1'b1, STATUS_OK);
    directed[3]  = mk(CMD_WORD, LETTER_A, 1'b1, 1, 1'b1, 0, 1'b0, STATUS_OK);
    // An empty word: only an uncounted code, carrying word_end.
    directed[4]  = mk(CMD_WORD, CODE_TOP, 1'b1, 1, 1'b1, 2, 1'b1, STATUS_OK);
    // Two anagrams, then an uncounted code in the middle of a word.
    directed[5]  = mk(CMD_WORD, LETTER_A, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[6]  = mk(CMD_WORD, 5'd1, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[7]  = mk(CMD_WORD, 5'd1, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[8]  = mk(CMD_WORD, LETTER_A, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[9]  = mk(CMD_WORD, CODE_FIRST_NOISE, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[10] = mk(CMD_WORD, LETTER_A, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    // A clear in the middle of a word drops the partial word and the table.
    directed[11] = mk(CMD_WORD, 5'd2, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[12] = mk(CMD_CLEAR, LETTER_A, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[13] = mk(CMD_WORD, LETTER_Z, 1'b1, 1, 1'b1, 0, 1'b1, STATUS_OK);
    // One letter past the length limit.
    directed[14] = mk(CMD_WORD, 5'd5, 1'b1, 33, 1'b1, 0, 1'b0, STATUS_LONG);
    // Exactly at the limit, with an uncounted code that must not overflow it.
    directed[15] = mk(CMD_WORD, 5'd6, 1'b0, 32, 1'b0, 0, 1'b0, STATUS_OK);
    directed[16] = mk(CMD_WORD, 5'd30, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    // At the limit, an uncounted code, then one counted letter too many.
    directed[17] = mk(CMD_WORD, 5'd6, 1'b0, 32, 1'b0, 0, 1'b0, STATUS_OK);
    directed[18] = mk(CMD_WORD, 5'd30, 1'b0, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[19] = mk(CMD_WORD, 5'd6, 1'b1, 1, 1'b1, 0, 1'b0, STATUS_LONG);
    directed[20] = mk(CMD_WORD, 5'd16, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);
    directed[21] = mk(CMD_WORD, 5'd15, 1'b1, 1, 1'b0, 0, 1'b0, STATUS_OK);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      for (j = 0; j < directed[i].reps; j++) begin
        offer(directed[i].c, directed[i].l,
              (j == directed[i].reps - 1) ? directed[i].e : 1'b0,
              (j == directed[i].reps - 1) ? directed[i].typed : 1'b0,
              directed[i].res);
      end
    end
    drain();

    // Pool of base words whose anagrams make up most of the random stream,
    // so that most words land in groups that already exist.
    for (slot = 0; slot < POOL_SIZE; slot++) begin
      pool_len[slot] = $urandom_range(1, POOL_LEN);
      for (k = 0; k < POOL_LEN; k++) pool[slot][k] = 5'($urandom_range(0, 25));
    end

    items_sent = 0;
    did_hold   = 1'b0;
    did_fill   = 1'b0;
    while (items_sent < RANDOM_ITEMS) begin
      if (!did_hold && items_sent >= 200) begin
        // The receiver stops for a long stretch while words keep coming.
        hold_request = 1'b1;
        did_hold     = 1'b1;
      end
      if (!did_fill && items_sent >= 420) begin
        // Pause until everything is out, then fill the table past its end
        // with words that are all different from each other.
        did_fill = 1'b1;
        drain();
        offer(CMD_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              1'b0, no_result);
        for (i = 0; i < MAX_GROUPS + 6; i++) begin
          n = i / ALPHABET_SIZE;
          wl[0] = 5'(i % ALPHABET_SIZE);
          for (k = 1; k <= n; k++) wl[k] = LETTER_Z;
          send_word(n + 1);
        end
      end
      calm = (items_sent >= CALM_ITEMS);

      r = $urandom_range(0, 99);
      if (r < 2) begin
        // Clear, now and then in the middle of a word.
        if ($urandom_range(0, 1)) begin
          repeat ($urandom_range(1, 4)) begin
            offer(CMD_WORD, 5'($urandom_range(0, 31)), 1'b0, 1'b0, no_result);
          end
        end
        offer(CMD_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              1'b0, no_result);
      end else if (r < 55) begin
        // A shuffled copy of a pool word.
        slot = $urandom_range(0, POOL_SIZE - 1);
        n    = pool_len[slot];
        for (k = 0; k < n; k++) wl[k] = pool[slot][k];
        for (k = n - 1; k > 0; k--) begin
          j     = $urandom_range(0, k);
          tmp   = wl[k];
          wl[k] = wl[j];
          wl[j] = tmp;
        end
        send_word(n);
      end else if (r < 80) begin
        // A fresh word, often kept in the pool for later anagrams.
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) wl[k] = 5'($urandom_range(0, 25));
        if ($urandom_range(0, 1)) begin
          slot           = $urandom_range(0, POOL_SIZE - 1);
          pool_len[slot] = n;
          for (k = 0; k < n; k++) pool[slot][k] = wl[k];
        end
        send_word(n);
      end else if (r < 88) begin
        // Words around the length limit, from a few letters so they repeat.
        n = $urandom_range(MAX_WORD_LEN - 4, MAX_WORD_LEN + 4);
        for (k = 0; k < n; k++) wl[k] = 5'($urandom_range(0, 3));
        send_word(n);
      end else if (r < 95) begin
        // Noisy words with uncounted codes mixed in, the last one included.
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) wl[k] = 5'($urandom_range(0, 31));
        send_word(n);
      end else begin
        // Empty words and lone letters.
        wl[0] = $urandom_range(0, 1) ? 5'($urandom_range(26, 31))
                                     : 5'($urandom_range(0, 25));
        send_word(1);
      end
    end

    drain();
    if (fail_count == 0 && expected_groups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
